// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files of the IR transmitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/ipdt_pkg.sv -----
// Shared types and constants of the pulse-distance IR transmitter.
package ipdt_pkg;

	// Waveform phases.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam logic [1:0] PH_GAP  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BURST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_BURST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_GAP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_GAP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_GAP      = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_CARRIER_HALF = 8'd46;
	localparam logic [7:0]  RST_START_BURST  = 8'd171;
	localparam logic [7:0]  RST_BIT_BURST    = 8'd21;
	localparam logic [15:0] RST_START_GAP    = 16'd36000;
	localparam logic [15:0] RST_ZERO_GAP     = 16'd4480;
	localparam logic [15:0] RST_ONE_GAP      = 16'd13520;

	// Symbol counter width; holds the data bits plus the start symbol.
	localparam int BITS_LEFT_W = 6;
	localparam int CODE_W = 32;

	typedef struct packed {
		logic [7:0]  carrier_half_ticks;
		logic [7:0]  start_burst_cycles;
		logic [7:0]  bit_burst_cycles;
		logic [15:0] start_gap_ticks;
		logic [15:0] zero_gap_ticks;
		logic [15:0] one_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic led_on;
		logic busy_res;
		logic load_rejected;
	} res_t;

endpackage

// ----- src/ipdt_if.sv -----
// Valid/ready channel interfaces for the transmitter's item and result streams.
interface ipdt_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] code;

	modport source (output valid, output mode, output code, input ready);
	modport sink (input valid, input mode, input code, output ready);
endinterface

interface ipdt_out_if;
	logic valid;
	logic ready;
	logic led_on;
	logic busy_res;
	logic load_rejected;

	modport source (output valid, output led_on, output busy_res, output load_rejected,
		input ready);
	modport sink (input valid, input led_on, input busy_res, input load_rejected,
		output ready);
endinterface

// ----- src/ipdt_cfg_regs.sv -----
// Configuration register bank of the IR transmitter.
module ipdt_cfg_regs
	import ipdt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carrier_half_ticks <= RST_CARRIER_HALF;
			cfg_q.start_burst_cycles <= RST_START_BURST;
			cfg_q.bit_burst_cycles   <= RST_BIT_BURST;
			cfg_q.start_gap_ticks    <= RST_START_GAP;
			cfg_q.zero_gap_ticks     <= RST_ZERO_GAP;
			cfg_q.one_gap_ticks      <= RST_ONE_GAP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CARRIER_HALF: cfg_q.carrier_half_ticks <= cfg_wdata[7:0];
				CFG_START_BURST:  cfg_q.start_burst_cycles <= cfg_wdata[7:0];
				CFG_BIT_BURST:    cfg_q.bit_burst_cycles   <= cfg_wdata[7:0];
				CFG_START_GAP:    cfg_q.start_gap_ticks    <= cfg_wdata;
				CFG_ZERO_GAP:     cfg_q.zero_gap_ticks     <= cfg_wdata;
				CFG_ONE_GAP:      cfg_q.one_gap_ticks      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/ipdt_core.sv -----
// Input stage and waveform state machine of the IR transmitter.
`include "assert_macros.svh"
module ipdt_core
	import ipdt_pkg::*;
#(
	parameter int CODE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_mode,
	input  logic [CODE_W-1:0] in_code,
	input  logic              space,
	output logic              push,
	output res_t              res
);

	localparam logic [BITS_LEFT_W-1:0] FRAME_SYMBOLS = BITS_LEFT_W'(CODE_BITS + 1);

	// Input stage.
	logic              valid_s1;
	logic              mode_s1;
	logic [CODE_W-1:0] code_s1;

	// Waveform state.
	logic [CODE_BITS-1:0]   code_q;
	logic [BITS_LEFT_W-1:0] bits_q;
	logic [1:0]             phase_q;
	logic [7:0]             bursts_q;
	logic [7:0]             half_q;
	logic [15:0]            gap_q;
	logic                   led_q;

	logic [CODE_BITS-1:0]   n_code;
	logic [BITS_LEFT_W-1:0] n_bits;
	logic [1:0]             n_phase;
	logic [7:0]             n_bursts;
	logic [7:0]             n_half;
	logic [15:0]            n_gap;
	logic                   n_led;
	logic                   n_rej;

	logic        fire;
	logic [7:0]  half_inc;
	logic        half_done;
	logic        in_start;
	logic [15:0] gap_target;
	logic [16:0] gap_inc;
	logic        gap_done;

	assign fire     = valid_s1 && space;
	assign in_ready = !valid_s1 || space;
	assign push     = fire;

	// Hold the accepted item until the result queue has room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= in_mode;
			code_s1 <= in_code;
		end
	end

	// Carrier half period and gap comparisons; a zero register acts as one.
	assign half_inc   = half_q + 8'd1;
	assign half_done  = (half_inc >= cfg.carrier_half_ticks) || (half_inc == 8'd0);
	assign in_start   = (bits_q == FRAME_SYMBOLS);
	assign gap_target = in_start ? cfg.start_gap_ticks :
		(code_q[CODE_BITS-1] ? cfg.one_gap_ticks : cfg.zero_gap_ticks);
	assign gap_inc    = {1'b0, gap_q} + 17'd1;
	assign gap_done   = (gap_inc >= {1'b0, gap_target});

	// Next state for a load or a tick.
	always_comb begin
		n_code   = code_q;
		n_bits   = bits_q;
		n_phase  = phase_q;
		n_bursts = bursts_q;
		n_half   = half_q;
		n_gap    = gap_q;
		n_led    = led_q;
		n_rej    = 1'b0;
		if (mode_s1) begin
			if (phase_q != PH_IDLE) begin
				n_rej = 1'b1;
			end else begin
				n_code   = code_s1[CODE_BITS-1:0];
				n_bits   = FRAME_SYMBOLS;
				n_bursts = cfg.start_burst_cycles;
				n_half   = 8'd0;
				n_gap    = 16'd0;
				n_led    = 1'b0;
				n_phase  = PH_HIGH;
			end
		end else begin
			case (phase_q)
				PH_HIGH: begin
					n_led = 1'b1;
					if (half_done) begin
						n_half  = 8'd0;
						n_phase = PH_LOW;
					end else begin
						n_half = half_inc;
					end
				end
				PH_LOW: begin
					n_led = 1'b0;
					if (half_done) begin
						n_half = 8'd0;
						if (bursts_q <= 8'd1) begin
							n_bursts = 8'd0;
							n_gap    = 16'd0;
							n_phase  = PH_GAP;
						end else begin
							n_bursts = bursts_q - 8'd1;
							n_phase  = PH_HIGH;
						end
					end else begin
						n_half = half_inc;
					end
				end
				PH_GAP: begin
					n_led = 1'b0;
					if (gap_done) begin
						n_gap = 16'd0;
						if (!in_start) begin
							n_code = code_q << 1;
						end
						n_bits = bits_q - BITS_LEFT_W'(1);
						if (n_bits == '0) begin
							n_phase = PH_IDLE;
						end else begin
							n_bursts = cfg.bit_burst_cycles;
							n_phase  = PH_HIGH;
						end
					end else begin
						n_gap = gap_inc[15:0];
					end
				end
				default: begin
					n_phase = PH_IDLE;
					n_led   = 1'b0;
				end
			endcase
		end
	end

	// State update on each processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q   <= '0;
			bits_q   <= '0;
			phase_q  <= PH_IDLE;
			bursts_q <= 8'd0;
			half_q   <= 8'd0;
			gap_q    <= 16'd0;
			led_q    <= 1'b0;
		end else if (fire) begin
			code_q   <= n_code;
			bits_q   <= n_bits;
			phase_q  <= n_phase;
			bursts_q <= n_bursts;
			half_q   <= n_half;
			gap_q    <= n_gap;
			led_q    <= n_led;
		end
	end

	assign res.led_on        = n_led;
	assign res.busy_res      = (n_phase != PH_IDLE);
	assign res.load_rejected = n_rej;

	`ASSERT_IMP(a_idle_no_symbols, clk, arst_n, phase_q == PH_IDLE, bits_q == '0, "idle with symbols left")
	`ASSERT_IMP(a_led_in_burst, clk, arst_n, led_q, phase_q == PH_HIGH || phase_q == PH_LOW, "LED lit outside a burst")
	`ASSERT_NXT(a_reject_holds, clk, arst_n, fire && mode_s1 && phase_q != PH_IDLE, $stable(code_q) && $stable(bits_q) && $stable(phase_q), "rejected load changed state")

endmodule

// ----- src/ipdt_out_q.sv -----
// Two-entry result queue that decouples the state machine from the receiver.
`include "assert_macros.svh"
module ipdt_out_q
	import ipdt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic space,
	output logic out_valid,
	input  logic out_ready,
	output res_t dout
);

	res_t       slot0_q;
	res_t       slot1_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign space     = (count_q != 2'd2);
	assign dout      = slot0_q;

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Head and second slot; the head always holds the oldest result.
	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				slot0_q <= din;
			end else begin
				slot1_q <= din;
			end
		end else if (pop && !push) begin
			slot0_q <= slot1_q;
		end else if (pop && push) begin
			if (count_q == 2'd1) begin
				slot0_q <= din;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= din;
			end
		end
	end

	`ASSERT_IMP(a_no_overflow, clk, arst_n, push, count_q != 2'd2, "push into a full queue")
	`ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q != 2'd3, "queue count out of range")
	`ASSERT_NXT(a_drain_full, clk, arst_n, count_q == 2'd2 && pop, count_q == 2'd1, "full queue did not drain")

endmodule

// ----- src/ir_pulse_distance_transmitter.sv -----
// Top level of the pulse-distance (NEC-style) infrared remote transmitter.
//
// Items arrive on in_ch (valid/ready). mode 1 loads a code and starts a frame
// when idle; mode 0 is one tick of the waveform timebase. Every item yields one
// result on out_ch: the LED level, the busy flag and a flag for a load that
// arrived during a frame and was dropped.
// A frame is a start burst and gap, then CODE_BITS symbols, MSB first, each a
// short carrier burst and a gap whose length encodes the bit.
// Throughput is one item per cycle while the output queue has space. An accepted
// item is registered in the input stage, then its result is written to a
// two-entry output queue and offered on out_ch from the queue head; the input
// stage holds the item while the queue is full.
// The receiver may stall freely: the queue absorbs one extra result and then
// in_ch.ready drops until space returns; no result is lost or repeated.
// Reset puts the registers at their default timing, the waveform idle with
// the LED off, and empties the input stage and the queue.
// Configuration writes through cfg_we/cfg_index/cfg_wdata are registered and take effect once stored.
module ir_pulse_distance_transmitter
	import ipdt_pkg::*;
#(
	parameter int CODE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ipdt_in_if.sink               in_ch,
	ipdt_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;
	logic space;
	logic push;
	res_t res;
	res_t dout;

	ipdt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ipdt_core #(
		.CODE_BITS (CODE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_mode  (in_ch.mode),
		.in_code  (in_ch.code),
		.space    (space),
		.push     (push),
		.res      (res)
	);

	ipdt_out_q u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res),
		.space     (space),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.dout      (dout)
	);

	assign out_ch.led_on        = dout.led_on;
	assign out_ch.busy_res      = dout.busy_res;
	assign out_ch.load_rejected = dout.load_rejected;

endmodule
